// ===== sv/uart8e_pkg.sv =====
// Package for the 8N1 serial transceiver with echo.
// Holds reset values, echo control codes and the receiver/transmitter phase types.
// No dependencies.
package uart8e_pkg;

  localparam int unsigned DATA_BITS_DEF = 8;
  localparam int unsigned PERIOD_W      = 16;
  localparam int unsigned BYTE_W        = 8;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd868;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD     = 16'd4;

  // received codes that switch echo mode
  localparam logic [BYTE_W-1:0] ECHO_ON_BYTE  = 8'h05;
  localparam logic [BYTE_W-1:0] ECHO_OFF_BYTE = 8'h06;

  typedef enum logic [1:0] {
    RX_IDLE = 2'd0,
    RX_DATA = 2'd1,
    RX_STOP = 2'd2
  } rx_phase_t;

  typedef enum logic [1:0] {
    TX_IDLE  = 2'd0,
    TX_START = 2'd1,
    TX_DATA  = 2'd2,
    TX_STOP  = 2'd3
  } tx_phase_t;

endpackage

// ===== sv/uart_8n1_with_echo_core.sv =====
// Top level of the 8N1 serial transceiver with echo mode.
// Depends on uart8e_pkg (constants, phase types).
//
// Usage:
//   Each word on the in_ channel is one clock tick of the serial line: the
//   sampled receive level plus an optional host send request. Each tick gives
//   exactly one word on the out_ channel: transmit level, received byte
//   strobe and data, send acknowledge, busy and echo flags.
//   Both channels use valid/stall; a word moves when valid is high and stall
//   is low. cfg_ sets bit_period (ticks per serial bit, values below 4 act
//   as 4); cfg_ready is always high, and writes belong in idle periods.
// Datapath: a word waits in the input register, the tick is evaluated and
//   the result lands in the output register, from which it is offered.
// Throughput: one word per cycle while the output is not stalled. The tick
//   logic (a 17-bit and a 16-bit decrement and compare for the two timers,
//   one-bit shifts) fits between the input and output registers, so nothing iterates.
// Reset (rst_n low, synchronous): both channels empty, receiver and
//   transmitter idle, echo off, bit_period back to 868.
// Receiver stall: the output register holds its word; once the input register
//   holds a word, in_stall rises in the same cycle as out_stall, so no tick
//   is lost and the serial state does not advance.
module uart_8n1_with_echo_core #(
  parameter int unsigned DATA_BITS = uart8e_pkg::DATA_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tick input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_rx_level,
  input  logic        in_send_valid,
  input  logic [7:0]  in_send_byte,
  // tick result
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_level,
  output logic        out_rx_valid,
  output logic [7:0]  out_rx_byte,
  output logic        out_send_accepted,
  output logic        out_tx_busy,
  output logic        out_echo_enabled,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_bit_period
);

  localparam int unsigned CNT_W = $clog2(DATA_BITS + 1);
  localparam int unsigned PW    = uart8e_pkg::PERIOD_W;
  localparam int unsigned RTW   = PW + 1;  // rx timer holds 1.5 periods

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  logic [PW-1:0] bit_period_r;
  logic [PW-1:0] period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= uart8e_pkg::BIT_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      bit_period_r <= cfg_bit_period;
    end
  end

  assign period = (bit_period_r < uart8e_pkg::MIN_PERIOD) ? uart8e_pkg::MIN_PERIOD
                                                          : bit_period_r;

  // ---------------------------------------------------------------------
  // input register and pipeline control
  // ---------------------------------------------------------------------
  logic       in_vld_r;
  logic       rx_level_r;
  logic       send_valid_r;
  logic [7:0] send_byte_r;
  logic       out_valid_r;
  logic       advance;

  // tick is evaluated when the input register holds a word and the
  // output register is free or draining
  assign advance  = in_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      rx_level_r   <= in_rx_level;
      send_valid_r <= in_send_valid;
      send_byte_r  <= in_send_byte;
    end
  end

  // ---------------------------------------------------------------------
  // serial state
  // ---------------------------------------------------------------------
  uart8e_pkg::rx_phase_t rx_phase_r, rx_phase_nxt;
  logic [RTW-1:0]        rx_timer_r, rx_timer_nxt;
  logic [CNT_W-1:0]      rx_bit_count_r, rx_bit_count_nxt;
  logic [DATA_BITS-1:0]  rx_shift_r, rx_shift_nxt;
  uart8e_pkg::tx_phase_t tx_phase_r, tx_phase_nxt;
  logic [PW-1:0]         tx_timer_r, tx_timer_nxt;
  logic [CNT_W-1:0]      tx_bit_count_r, tx_bit_count_nxt;
  logic [DATA_BITS-1:0]  tx_shift_r, tx_shift_nxt;
  logic                  echo_on_r, echo_on_nxt;
  logic                  echo_pending_r, echo_pending_nxt;
  logic [DATA_BITS-1:0]  echo_hold_r, echo_hold_nxt;

  // receiver results handed to the transmitter within the same tick
  logic                  rx_done;
  logic                  pend_mid;
  logic [DATA_BITS-1:0]  hold_mid;
  logic                  send_taken;
  logic [RTW-1:0]        start_wait;   // 1.5 bit periods
  logic [CNT_W-1:0]      rx_cnt_inc;
  logic [CNT_W-1:0]      tx_cnt_inc;

  assign start_wait = {1'b0, period} + {2'b00, period[PW-1:1]};
  assign rx_cnt_inc = rx_bit_count_r + 1'b1;
  assign tx_cnt_inc = tx_bit_count_r + 1'b1;

  // ---- receiver next state ----
  always_comb begin
    rx_phase_nxt     = rx_phase_r;
    rx_timer_nxt     = rx_timer_r;
    rx_bit_count_nxt = rx_bit_count_r;
    rx_shift_nxt     = rx_shift_r;
    echo_on_nxt      = echo_on_r;
    pend_mid         = echo_pending_r;
    hold_mid         = echo_hold_r;
    rx_done          = 1'b0;
    case (rx_phase_r)
      uart8e_pkg::RX_DATA: begin
        if (rx_timer_r > RTW'(1)) begin
          rx_timer_nxt = rx_timer_r - 1'b1;
        end else begin
          // LSB first: new bit enters at the top
          rx_shift_nxt     = {rx_level_r, rx_shift_r[DATA_BITS-1:1]};
          rx_bit_count_nxt = rx_cnt_inc;
          rx_timer_nxt     = {1'b0, period};
          if (rx_cnt_inc >= CNT_W'(DATA_BITS)) begin
            rx_phase_nxt = uart8e_pkg::RX_STOP;
          end
        end
      end
      uart8e_pkg::RX_STOP: begin
        if (rx_timer_r > RTW'(1)) begin
          rx_timer_nxt = rx_timer_r - 1'b1;
        end else begin
          rx_done = 1'b1;
          if (echo_on_r) begin
            pend_mid = 1'b1;   // overwrites an echo still waiting
            hold_mid = rx_shift_r;
          end
          if (rx_shift_r == DATA_BITS'(uart8e_pkg::ECHO_ON_BYTE)) begin
            echo_on_nxt = 1'b1;
          end
          if (rx_shift_r == DATA_BITS'(uart8e_pkg::ECHO_OFF_BYTE)) begin
            echo_on_nxt = 1'b0;
          end
          rx_phase_nxt     = uart8e_pkg::RX_IDLE;
          rx_timer_nxt     = '0;
          rx_bit_count_nxt = '0;
        end
      end
      default: begin
        // idle, and the unused phase code
        rx_phase_nxt = uart8e_pkg::RX_IDLE;
        if (!rx_level_r) begin
          rx_phase_nxt     = uart8e_pkg::RX_DATA;
          rx_timer_nxt     = start_wait;
          rx_bit_count_nxt = '0;
          rx_shift_nxt     = '0;
        end
      end
    endcase
  end

  // ---- transmitter next state ----
  always_comb begin
    tx_phase_nxt     = tx_phase_r;
    tx_timer_nxt     = tx_timer_r;
    tx_bit_count_nxt = tx_bit_count_r;
    tx_shift_nxt     = tx_shift_r;
    echo_pending_nxt = pend_mid;
    echo_hold_nxt    = hold_mid;
    send_taken       = 1'b0;

    // advance the running frame
    if (tx_phase_r != uart8e_pkg::TX_IDLE) begin
      if (tx_timer_r > PW'(1)) begin
        tx_timer_nxt = tx_timer_r - 1'b1;
      end else begin
        case (tx_phase_r)
          uart8e_pkg::TX_START: begin
            tx_phase_nxt     = uart8e_pkg::TX_DATA;
            tx_bit_count_nxt = '0;
            tx_timer_nxt     = period;
          end
          uart8e_pkg::TX_DATA: begin
            tx_shift_nxt     = tx_shift_r >> 1;
            tx_bit_count_nxt = tx_cnt_inc;
            tx_timer_nxt     = period;
            if (tx_cnt_inc >= CNT_W'(DATA_BITS)) begin
              tx_phase_nxt = uart8e_pkg::TX_STOP;
            end
          end
          default: begin
            tx_phase_nxt = uart8e_pkg::TX_IDLE;
            tx_timer_nxt = '0;
          end
        endcase
      end
    end

    // start a frame on the same tick the line becomes free; echo first
    if (tx_phase_nxt == uart8e_pkg::TX_IDLE) begin
      if (pend_mid) begin
        tx_shift_nxt     = hold_mid;
        echo_pending_nxt = 1'b0;
        tx_phase_nxt     = uart8e_pkg::TX_START;
        tx_timer_nxt     = period;
        tx_bit_count_nxt = '0;
      end else if (send_valid_r) begin
        tx_shift_nxt     = DATA_BITS'(send_byte_r);
        send_taken       = 1'b1;
        tx_phase_nxt     = uart8e_pkg::TX_START;
        tx_timer_nxt     = period;
        tx_bit_count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_phase_r     <= uart8e_pkg::RX_IDLE;
      rx_timer_r     <= '0;
      rx_bit_count_r <= '0;
      rx_shift_r     <= '0;
      tx_phase_r     <= uart8e_pkg::TX_IDLE;
      tx_timer_r     <= '0;
      tx_bit_count_r <= '0;
      tx_shift_r     <= '0;
      echo_on_r      <= 1'b0;
      echo_pending_r <= 1'b0;
      echo_hold_r    <= '0;
    end else if (advance) begin
      rx_phase_r     <= rx_phase_nxt;
      rx_timer_r     <= rx_timer_nxt;
      rx_bit_count_r <= rx_bit_count_nxt;
      rx_shift_r     <= rx_shift_nxt;
      tx_phase_r     <= tx_phase_nxt;
      tx_timer_r     <= tx_timer_nxt;
      tx_bit_count_r <= tx_bit_count_nxt;
      tx_shift_r     <= tx_shift_nxt;
      echo_on_r      <= echo_on_nxt;
      echo_pending_r <= echo_pending_nxt;
      echo_hold_r    <= echo_hold_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // result word
  // ---------------------------------------------------------------------
  logic       tx_level_nxt;
  logic       tx_busy_nxt;
  logic [7:0] rx_byte_nxt;

  always_comb begin
    case (tx_phase_nxt)
      uart8e_pkg::TX_START: tx_level_nxt = 1'b0;
      uart8e_pkg::TX_DATA:  tx_level_nxt = tx_shift_nxt[0];
      default:              tx_level_nxt = 1'b1;
    endcase
    tx_busy_nxt = (tx_phase_nxt != uart8e_pkg::TX_IDLE) || echo_pending_nxt;
    rx_byte_nxt = rx_done ? 8'(rx_shift_r) : 8'h00;
  end

  logic       out_tx_level_r;
  logic       out_rx_valid_r;
  logic [7:0] out_rx_byte_r;
  logic       out_send_accepted_r;
  logic       out_tx_busy_r;
  logic       out_echo_enabled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= advance || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tx_level_r      <= tx_level_nxt;
      out_rx_valid_r      <= rx_done;
      out_rx_byte_r       <= rx_byte_nxt;
      out_send_accepted_r <= send_taken;
      out_tx_busy_r       <= tx_busy_nxt;
      out_echo_enabled_r  <= echo_on_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tx_level      = out_tx_level_r;
  assign out_rx_valid      = out_rx_valid_r;
  assign out_rx_byte       = out_rx_byte_r;
  assign out_send_accepted = out_send_accepted_r;
  assign out_tx_busy       = out_tx_busy_r;
  assign out_echo_enabled  = out_echo_enabled_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // an idle transmitter always picks up a waiting echo in the same tick
  a_echo_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && tx_phase_r == uart8e_pkg::TX_IDLE) |=> !echo_pending_r)
    else $error("echo left pending behind an idle transmitter");

  // a taken host send leaves the transmitter busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_send_accepted_r) |-> out_tx_busy_r)
    else $error("send accepted but transmitter not busy");

  // received byte field is zero outside its strobe
  a_rx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rx_valid_r) |-> (out_rx_byte_r == 8'h00))
    else $error("rx byte nonzero without strobe");

  // bit counters stay within the frame
  a_rx_count: assert property (@(posedge clk) disable iff (!rst_n)
    rx_bit_count_r <= CNT_W'(DATA_BITS))
    else $error("rx bit count overflow");

  a_tx_count: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_phase_r == uart8e_pkg::TX_DATA) |-> (tx_bit_count_r < CNT_W'(DATA_BITS)))
    else $error("tx bit count overflow in data phase");

  // a stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_tx_level_r)))
    else $error("stalled result changed");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for uart_8n1_with_echo_core: serial line ticks in, one result word out.
// Holds its own line model, the stimulus tasks and the result checker.
// Depends on uart8e_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  // one result word as the core reports it
  typedef struct packed {
    logic       tx_level;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       send_accepted;
    logic       tx_busy;
    logic       echo_enabled;
  } tick_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_rx_level = 1'b1;
  logic        in_send_valid = 1'b0;
  logic [7:0]  in_send_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_tx_level;
  logic        out_rx_valid;
  logic [7:0]  out_rx_byte;
  logic        out_send_accepted;
  logic        out_tx_busy;
  logic        out_echo_enabled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_bit_period = uart8e_pkg::BIT_PERIOD_RST;

  uart_8n1_with_echo_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_level       (in_rx_level),
    .in_send_valid     (in_send_valid),
    .in_send_byte      (in_send_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tx_level      (out_tx_level),
    .out_rx_valid      (out_rx_valid),
    .out_rx_byte       (out_rx_byte),
    .out_send_accepted (out_send_accepted),
    .out_tx_busy       (out_tx_busy),
    .out_echo_enabled  (out_echo_enabled),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_bit_period    (cfg_bit_period)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Line model state. Starts out at the post-reset values; reset is applied once.
  // ---------------------------------------------------------------------------
  logic [15:0]           baud_ticks     = uart8e_pkg::BIT_PERIOD_RST;
  uart8e_pkg::rx_phase_t rcv_phase      = uart8e_pkg::RX_IDLE;
  logic [16:0]           rcv_count_down = '0;
  logic [3:0]            rcv_bits       = '0;
  logic [7:0]            rcv_sr         = '0;
  uart8e_pkg::tx_phase_t xmt_phase      = uart8e_pkg::TX_IDLE;
  logic [15:0]           xmt_count_down = '0;
  logic [3:0]            xmt_bits       = '0;
  logic [7:0]            xmt_sr         = '0;
  logic                  echo_mode      = 1'b0;
  logic                  echo_due       = 1'b0;
  logic [7:0]            echo_byte      = '0;

  tick_word_t expected_words[$];   // predicted words, oldest first
  logic       line_q[$];           // rx levels still to be played, one per tick

  int  fault_count   = 0;
  int  checked_words = 0;
  int  tick_total    = 0;
  int  bytes_heard   = 0;
  int  sends_taken   = 0;
  int  echo_loads    = 0;
  int  cycle_count   = 0;
  int  stall_cycles  = 0;
  int  sink_hold_cycles = 0;   // long receiver hold-off requested by a test
  bit  idling_on     = 1'b1;   // random gaps on both channels

  // periods under 4 behave as 4
  function automatic int unsigned line_period();
    return (baud_ticks < uart8e_pkg::MIN_PERIOD) ? int'(uart8e_pkg::MIN_PERIOD)
                                                 : int'(baud_ticks);
  endfunction

  // Advance the model by one tick. Receiver first, then the transmitter, so a
  // byte finishing this tick can start its echo in the same tick.
  function automatic tick_word_t advance_line(input logic rx, input logic req,
                                              input logic [7:0] req_byte);
    tick_word_t  w;
    int unsigned eff;
    logic [7:0]  got;
    eff = line_period();
    w = '0;

    case (rcv_phase)
      uart8e_pkg::RX_DATA: begin
        if (rcv_count_down > 17'd1) begin
          rcv_count_down--;
        end else begin
          rcv_sr = {rx, rcv_sr[7:1]};   // LSB first
          rcv_bits++;
          rcv_count_down = 17'(eff);
          if (rcv_bits >= uart8e_pkg::BYTE_W) rcv_phase = uart8e_pkg::RX_STOP;
        end
      end
      uart8e_pkg::RX_STOP: begin
        // stop bit is timed but never checked
        if (rcv_count_down > 17'd1) begin
          rcv_count_down--;
        end else begin
          got = rcv_sr;
          w.rx_valid = 1'b1;
          w.rx_byte = got;
          bytes_heard++;
          if (echo_mode) begin
            // a newer byte overwrites an echo still waiting
            echo_due = 1'b1;
            echo_byte = got;
          end
          if (got == uart8e_pkg::ECHO_ON_BYTE) echo_mode = 1'b1;
          if (got == uart8e_pkg::ECHO_OFF_BYTE) echo_mode = 1'b0;
          rcv_phase = uart8e_pkg::RX_IDLE;
          rcv_count_down = '0;
          rcv_bits = '0;
        end
      end
      default: begin
        rcv_phase = uart8e_pkg::RX_IDLE;
        if (!rx) begin
          rcv_phase = uart8e_pkg::RX_DATA;
          rcv_count_down = 17'((3 * eff) / 2);   // to the middle of data bit 0
          rcv_bits = '0;
          rcv_sr = '0;
        end
      end
    endcase

    if (xmt_phase != uart8e_pkg::TX_IDLE) begin
      if (xmt_count_down > 16'd1) begin
        xmt_count_down--;
      end else if (xmt_phase == uart8e_pkg::TX_START) begin
        xmt_phase = uart8e_pkg::TX_DATA;
        xmt_bits = '0;
        xmt_count_down = 16'(eff);
      end else if (xmt_phase == uart8e_pkg::TX_DATA) begin
        xmt_sr = xmt_sr >> 1;
        xmt_bits++;
        xmt_count_down = 16'(eff);
        if (xmt_bits >= uart8e_pkg::BYTE_W) xmt_phase = uart8e_pkg::TX_STOP;
      end else begin
        xmt_phase = uart8e_pkg::TX_IDLE;
        xmt_count_down = '0;
      end
    end

    // a frame may start on the tick the previous stop bit ends; echo wins
    if (xmt_phase == uart8e_pkg::TX_IDLE) begin
      if (echo_due) begin
        xmt_sr = echo_byte;
        echo_due = 1'b0;
        xmt_phase = uart8e_pkg::TX_START;
        xmt_count_down = 16'(eff);
        xmt_bits = '0;
        echo_loads++;
      end else if (req) begin
        xmt_sr = req_byte;
        w.send_accepted = 1'b1;
        xmt_phase = uart8e_pkg::TX_START;
        xmt_count_down = 16'(eff);
        xmt_bits = '0;
        sends_taken++;
      end
    end

    if (xmt_phase == uart8e_pkg::TX_START) w.tx_level = 1'b0;
    else if (xmt_phase == uart8e_pkg::TX_DATA) w.tx_level = xmt_sr[0];
    else w.tx_level = 1'b1;
    w.tx_busy = (xmt_phase != uart8e_pkg::TX_IDLE) || echo_due;
    w.echo_enabled = echo_mode;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one tick per word. Payload holds while stalled.
  // ---------------------------------------------------------------------------
  task automatic drive_tick(input logic rx, input logic req, input logic [7:0] req_byte);
    if (idling_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_rx_level   <= rx;
    in_send_valid <= req;
    in_send_byte  <= req_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(advance_line(rx, req, req_byte));
    tick_total++;
  endtask

  // drop valid and let every predicted word come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // only called with the core drained, so the model can switch at once
  task automatic write_period(input logic [15:0] ticks);
    cfg_valid      <= 1'b1;
    cfg_bit_period <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    baud_ticks = ticks;
  endtask

  // queue one frame on the rx line: start, 8 data LSB first, stop, idle gap
  task automatic add_frame(input logic [7:0] d, input int bit_len, input int stop_len,
                           input int gap_len);
    repeat (bit_len) line_q.push_back(1'b0);
    for (int i = 0; i < uart8e_pkg::BYTE_W; i++) begin
      repeat (bit_len) line_q.push_back(d[i]);
    end
    repeat (stop_len + gap_len) line_q.push_back(1'b1);
  endtask

  // play the queued line; host asks to send a random byte on send_pct% of ticks
  task automatic play_line(input int send_pct);
    logic lvl;
    while (line_q.size() != 0) begin
      lvl = line_q.pop_front();
      drive_tick(lvl, 1'($urandom_range(0, 99) < send_pct), 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset period of 868: host word 0xFF holds the start bit for 868 ticks. The
  // period drops to 4 early in the start bit; the running timer finishes at 868
  // and the data bits then run at 4. Requests made while busy are refused.
  task automatic test_reset_period();
    drive_tick(1'b1, 1'b1, 8'hFF);
    repeat (100) drive_tick(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    wait_drained();
    write_period(16'd4);
    repeat (820) drive_tick(1'b1, 1'($urandom_range(0, 3) == 0), 8'($urandom_range(0, 255)));
  endtask

  // Periods 0, 3 and 1 all act as 4. Extreme and alternating bytes on both directions.
  task automatic test_short_periods();
    logic [15:0] periods[3] = '{16'd0, 16'd3, 16'd1};
    logic [7:0]  rx_data[3] = '{8'h00, 8'hFF, 8'hA5};
    logic [7:0]  tx_data[3] = '{8'hFF, 8'h00, 8'h5A};
    for (int i = 0; i < 3; i++) begin
      wait_drained();
      write_period(periods[i]);
      add_frame(rx_data[i], 4, 4, 2);
      // host word and start bit arrive on the same tick
      drive_tick(line_q.pop_front(), 1'b1, tx_data[i]);
      play_line(0);
    end
  endtask

  // Echo on/off codes, echo priority over host words, and echo overrun: frames
  // with a stop bit cut to just past the sample point arrive faster than the
  // transmitter can send them back.
  task automatic test_echo_mode();
    int unsigned p;
    wait_drained();
    write_period(16'd5);
    p = line_period();
    add_frame(uart8e_pkg::ECHO_OFF_BYTE, p, p, 3);   // echo already off: nothing sent back
    add_frame(uart8e_pkg::ECHO_ON_BYTE, p, p, 3);    // turns echo on, itself not echoed
    add_frame(8'h3C, p, p, 2);
    play_line(30);
    add_frame(8'hFF, p, p / 2 + 1, 0);
    add_frame(8'h00, p, p / 2 + 1, 0);
    add_frame(8'h81, p, p / 2 + 1, 0);
    add_frame(8'h7E, p, p / 2 + 1, 0);
    add_frame(uart8e_pkg::ECHO_ON_BYTE, p, p / 2 + 1, 0);   // echoed while on
    play_line(50);
    add_frame(uart8e_pkg::ECHO_OFF_BYTE, p, p, 2);   // echoed, then echo off
    add_frame(8'h42, p, p, 4);                       // not echoed
    play_line(20);
  endtask

  // Receiver holds off for a long stretch while ticks keep coming, so the core
  // fills and stalls its input. Then the sender waits for every result.
  task automatic test_backpressure();
    int unsigned p;
    p = line_period();
    sink_hold_cycles = 60;
    for (int i = 0; i < 2; i++) add_frame(8'($urandom_range(0, 255)), p, p, $urandom_range(0, 4));
    play_line(25);
    wait_drained();
    add_frame(8'($urandom_range(0, 255)), p, p, $urandom_range(0, 4));
    play_line(25);
  endtask

  // Random phases, each at its own period. Mostly clean frames with random
  // content, plus skewed bit widths, missing stop bits, short glitches and
  // noise. The last phase runs with no idling on either side.
  task automatic test_random_traffic();
    int unsigned p;
    int unsigned pick;
    int          send_pct;
    logic [7:0]  d;
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      idling_on = (ph < 2);
      if ($urandom_range(0, 9) == 0) write_period(16'($urandom_range(0, 3)));
      else write_period(16'($urandom_range(4, 10)));
      p = line_period();
      send_pct = $urandom_range(0, 40);
      while (line_q.size() < 30) begin
        pick = $urandom_range(0, 99);
        d = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) begin
          d = $urandom_range(0, 1) ? uart8e_pkg::ECHO_ON_BYTE : uart8e_pkg::ECHO_OFF_BYTE;
        end
        if (pick < 60) begin
          add_frame(d, p, ($urandom_range(0, 3) == 0) ? p / 2 + 1 : p, $urandom_range(0, p));
        end else if (pick < 70) begin
          add_frame(d, $urandom_range(0, 1) ? p + 1 : p - 1, p, $urandom_range(0, p));
        end else if (pick < 80) begin
          add_frame(d, p, 0, 0);   // no stop bit: next start follows at once
        end else if (pick < 90) begin
          repeat ($urandom_range(1, p)) line_q.push_back(1'b0);
          repeat (2 * p) line_q.push_back(1'b1);
        end else begin
          repeat ($urandom_range(1, 20)) line_q.push_back(1'($urandom_range(0, 1)));
        end
      end
      play_line(send_pct);
    end
  endtask

  // Largest period: timers load with 65535 and 98302; only the first ticks are run.
  task automatic test_max_period();
    wait_drained();
    write_period(16'hFFFF);
    drive_tick(1'b1, 1'b1, 8'h80);
    repeat (10) drive_tick(1'b0, 1'b1, 8'h7F);
    repeat (20) drive_tick(1'($urandom_range(0, 1)), 1'b1, 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus the long hold-off when asked.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int held;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (sink_hold_cycles > 0) begin
          out_stall <= 1'b1;
          held = 0;
          while (held < sink_hold_cycles) begin
            @(posedge clk);
            held++;
          end
          sink_hold_cycles = 0;
          out_stall <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 5)) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_words
    tick_word_t seen;
    tick_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_tx_level, out_rx_valid, out_rx_byte, out_send_accepted,
               out_tx_busy, out_echo_enabled};
      if (expected_words.size() == 0) begin
        if (fault_count < 10) $display("result word %0d arrived with none expected", checked_words);
        fault_count++;
      end else begin
        want = expected_words.pop_front();
        if (seen !== want) begin
          if (fault_count < 10) begin
            $display("word %0d: expected tx=%b rxv=%b rxb=%h acc=%b busy=%b echo=%b",
                     checked_words, want.tx_level, want.rx_valid, want.rx_byte,
                     want.send_accepted, want.tx_busy, want.echo_enabled);
            $display("word %0d: actual   tx=%b rxv=%b rxb=%h acc=%b busy=%b echo=%b",
                     checked_words, seen.tx_level, seen.rx_valid, seen.rx_byte,
                     seen.send_accepted, seen.tx_busy, seen.echo_enabled);
          end
          fault_count++;
        end
      end
      checked_words++;
    end
  end

  // watchdog, plus a count of cycles the core pushed back on its input
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && in_stall) stall_cycles++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL uart_8n1_with_echo_core");
      $finish;
    end
  end

  initial begin : main
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_period();
    test_short_periods();
    test_echo_mode();
    test_backpressure();
    test_random_traffic();
    test_max_period();
    wait_drained();
    // wait on so that any stray word is caught
    repeat (10) @(posedge clk);
    $display("Ran %0d ticks: %0d bytes received, %0d host words sent, %0d echoes",
             tick_total, bytes_heard, sends_taken, echo_loads);
    $display("Periods from 0 to 65535, %0d cycles of input stall, %0d mismatches",
             stall_cycles, fault_count);
    if (fault_count == 0) begin
      $display("PASS uart_8n1_with_echo_core");
    end else begin
      $display("FAIL uart_8n1_with_echo_core");
    end
    $finish;
  end

endmodule

// ===== uart_8n1_with_echo_core.f =====
sv/uart8e_pkg.sv
sv/uart_8n1_with_echo_core.sv
tb/sv/tb.sv
